FILE: design/lmtt_pkg.sv
// Shared constants, types and helpers for the local mean triple threshold block.
`timescale 1ns / 1ps

package lmtt_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int COORD_W  = 9;                     // pixel_x / pixel_y
    localparam int DIM_W    = 10;                    // image_width / image_height
    localparam int ADDR_W   = 2 * COORD_W;           // row-major {row, col}
    localparam int SAMPLE_W = 8;
    localparam int HALF_W   = 8;                     // window half-size, at most 128
    localparam int ROWSUM_W = 17;
    localparam int INTEG_W  = 26;
    localparam int AREA_W   = 19;                    // pixel count, at most 512*512
    localparam int PROD_W   = SAMPLE_W + AREA_W;     // sample * count

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [DIM_W-1:0] MAX_WIDTH_V  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_V = DIM_W'(MAX_HEIGHT);

    // opcodes carried on s_tuser
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // class codes
    localparam logic [1:0] CLS_CERTAIN_BG  = 2'd0;
    localparam logic [1:0] CLS_PROBABLE_BG = 2'd1;
    localparam logic [1:0] CLS_PROBABLE_FG = 2'd2;
    localparam logic [1:0] CLS_CERTAIN_FG  = 2'd3;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_LD_RD  = 9'b000000010,
        ST_LD_WR  = 9'b000000100,
        ST_CL_RD0 = 9'b000001000,
        ST_CL_RD1 = 9'b000010000,
        ST_CL_RD2 = 9'b000100000,
        ST_CL_RD3 = 9'b001000000,
        ST_CL_SUM = 9'b010000000,
        ST_CL_RES = 9'b100000000
    } state_t;

    // zero reads as one, anything above the maximum reads as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: design/local_mean_triple_threshold.sv
// Top level: adaptive triple-threshold classifier over a stored saliency frame.
`timescale 1ns / 1ps

// Load items (s_tuser = 0) bring 8-bit saliency samples in raster order; each one
// is written to a sample memory and an integral-image memory, and the frame peak
// is tracked. After the last pixel of the frame, classify items (s_tuser = 1) name
// a pixel; the block sums a square window around it (half-size max(2,W/2)/2,
// clipped to the image) from four integral reads and compares the pixel with the
// local mean m, (m+peak)/2 and (3m+peak)/4 by exact cross-multiplication. One
// item is in work at a time. A load reads the integral of the row above, then
// writes back. A classify makes four reads in turn through the single port of
// the integral memory, then closes the sum, then compares; a refused classify
// (frame not complete, or pixel outside the image) skips the reads and the sum.
// The result sits in an output register, so the next item is taken while it
// waits. Writing either register restarts loading at pixel 0,0 and drops frame
// completion; write registers only when the block is idle. The memories come
// up undefined and need no clearing pass.
module local_mean_triple_threshold (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] sample, [16:8] pixel_x, [25:17] pixel_y, [31:26] zero
    input  logic [lmtt_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                            s_tuser,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] class_code, [7:2] zero
    output logic [lmtt_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] refused
    output logic                            m_tuser,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lmtt_pkg::APB_AW-1:0]     paddr,
    input  logic [lmtt_pkg::APB_DW-1:0]     pwdata,
    output logic [lmtt_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int CW = lmtt_pkg::COORD_W;
    localparam int DW = lmtt_pkg::DIM_W;
    localparam int IW = lmtt_pkg::INTEG_W;
    localparam int SW = lmtt_pkg::SAMPLE_W;
    localparam int AW = lmtt_pkg::ADDR_W;
    localparam int NW = lmtt_pkg::AREA_W;
    localparam int PW = lmtt_pkg::PROD_W;
    localparam int HW = lmtt_pkg::HALF_W;
    localparam int RW = lmtt_pkg::ROWSUM_W;
    localparam int DEPTH = lmtt_pkg::MAX_WIDTH * lmtt_pkg::MAX_HEIGHT;

    // ---------------- state ----------------
    lmtt_pkg::state_t state_reg, state_next;

    logic [DW-1:0] width_reg, width_next;
    logic [DW-1:0] height_reg, height_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [RW-1:0] rowsum_reg, rowsum_next;
    logic [SW-1:0] peak_reg, peak_next;
    logic          fc_reg, fc_next;          // frame complete
    logic          m_valid_reg, m_valid_next;

    // payload, no reset
    logic [1:0]    m_class_reg, m_class_next;
    logic          m_refused_reg, m_refused_next;
    logic [SW-1:0] ld_sample_reg, ld_sample_next;
    logic [CW-1:0] px_reg, px_next;
    logic [CW-1:0] py_reg, py_next;
    logic [CW-1:0] x1_reg, x1_next;
    logic [CW-1:0] x2_reg, x2_next;
    logic [CW-1:0] y1_reg, y1_next;
    logic [CW-1:0] y2_reg, y2_next;
    logic          refuse_reg, refuse_next;
    logic [NW-1:0] n_reg, n_next;
    logic [PW-1:0] sn_reg, sn_next;
    logic [PW-1:0] pn_reg, pn_next;
    logic [IW-1:0] sum_reg, sum_next;

    // ---------------- memories ----------------
    logic [SW-1:0] samp_mem [DEPTH];
    logic [IW-1:0] integ_mem [DEPTH];
    logic [SW-1:0] samp_rdata_reg;
    logic [IW-1:0] integ_rdata_reg;
    logic [AW-1:0] samp_addr, integ_addr;
    logic          samp_we, integ_we;
    logic [IW-1:0] integ_wdata;

    // ---------------- input fields ----------------
    logic          in_op;
    logic [SW-1:0] in_sample;
    logic [CW-1:0] in_x, in_y;
    assign in_op     = s_tuser;
    assign in_sample = s_tdata[7:0];
    assign in_x      = s_tdata[16:8];
    assign in_y      = s_tdata[25:17];

    // ---------------- geometry ----------------
    logic [DW-1:0] eff_w, eff_h, w_m1, h_m1;
    logic [CW-1:0] half_w_div2;
    logic [HW-1:0] half;
    logic [DW-1:0] x_hi_sum, y_hi_sum;
    logic [CW-1:0] win_x1, win_x2, win_y1, win_y2;
    logic          in_refuse;

    assign eff_w       = lmtt_pkg::eff_dim(width_reg, lmtt_pkg::MAX_WIDTH_V);
    assign eff_h       = lmtt_pkg::eff_dim(height_reg, lmtt_pkg::MAX_HEIGHT_V);
    assign w_m1        = eff_w - DW'(1);
    assign h_m1        = eff_h - DW'(1);
    assign half_w_div2 = eff_w[DW-1:1];
    assign half        = (half_w_div2 < CW'(2)) ? HW'(1) : half_w_div2[CW-1:1];

    assign x_hi_sum = {1'b0, in_x} + DW'(half);
    assign y_hi_sum = {1'b0, in_y} + DW'(half);
    assign win_x1   = (in_x > CW'(half)) ? in_x - CW'(half) : '0;
    assign win_y1   = (in_y > CW'(half)) ? in_y - CW'(half) : '0;
    assign win_x2   = (x_hi_sum > w_m1) ? w_m1[CW-1:0] : x_hi_sum[CW-1:0];
    assign win_y2   = (y_hi_sum > h_m1) ? h_m1[CW-1:0] : y_hi_sum[CW-1:0];
    assign in_refuse = !fc_reg || ({1'b0, in_x} >= eff_w) || ({1'b0, in_y} >= eff_h);

    logic x_lo, y_lo;   // window does not touch the left / top edge
    assign x_lo = (x1_reg != '0);
    assign y_lo = (y1_reg != '0);

    // ---------------- arithmetic ----------------
    logic [DW-1:0]   dx, dy;
    logic [2*DW-1:0] area;
    logic [PW-1:0]   sn_prod, pn_prod;
    assign dx      = {1'b0, x2_reg} - {1'b0, x1_reg} + DW'(1);
    assign dy      = {1'b0, y2_reg} - {1'b0, y1_reg} + DW'(1);
    assign area    = dx * dy;
    assign sn_prod = samp_rdata_reg * n_reg;
    assign pn_prod = peak_reg * n_reg;

    // class tests: s*N <= S, 2sN > S+PN, 4sN <= 3S+PN
    logic [PW+1:0] s_x4, s3_pn;
    logic [PW:0]   s_x2, s_pn;
    logic          t_bg, t_fg, t_pbg;
    logic [1:0]    cls;
    assign s_x2  = {sn_reg, 1'b0};
    assign s_x4  = {sn_reg, 2'b00};
    assign s_pn  = (PW+1)'(sum_reg) + (PW+1)'(pn_reg);
    assign s3_pn = (PW+2)'({sum_reg, 1'b0}) + (PW+2)'(sum_reg) + (PW+2)'(pn_reg);
    assign t_bg  = (sn_reg <= PW'(sum_reg));
    assign t_fg  = (s_x2 > s_pn);
    assign t_pbg = (s_x4 <= s3_pn);
    assign cls   = t_bg  ? lmtt_pkg::CLS_CERTAIN_BG  :
                   t_fg  ? lmtt_pkg::CLS_CERTAIN_FG  :
                   t_pbg ? lmtt_pkg::CLS_PROBABLE_BG : lmtt_pkg::CLS_PROBABLE_FG;

    // ---------------- load path ----------------
    logic          ld_first;
    logic [RW-1:0] ld_rowsum;
    logic [DW-1:0] col_inc, row_inc;
    assign ld_first    = (col_reg == '0) && (row_reg == '0);
    assign ld_rowsum   = ((col_reg == '0) ? '0 : rowsum_reg) + RW'(ld_sample_reg);
    assign integ_wdata = IW'(ld_rowsum) + ((row_reg != '0) ? integ_rdata_reg : '0);
    assign col_inc     = {1'b0, col_reg} + DW'(1);
    assign row_inc     = {1'b0, row_reg} + DW'(1);

    // ---------------- config port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lmtt_pkg::REG_HEIGHT) ? lmtt_pkg::APB_DW'(height_reg)
                                                       : lmtt_pkg::APB_DW'(width_reg);

    // ---------------- handshakes ----------------
    assign s_tready = (state_reg == lmtt_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lmtt_pkg::M_TDATA_W'(m_class_reg);
    assign m_tuser  = m_refused_reg;

    // ---------------- memory ports ----------------
    always_comb begin
        case (state_reg)
            lmtt_pkg::ST_LD_RD:  integ_addr = {row_reg - CW'(1), col_reg};
            lmtt_pkg::ST_LD_WR:  integ_addr = {row_reg, col_reg};
            lmtt_pkg::ST_CL_RD1: integ_addr = {y2_reg, x1_reg - CW'(1)};
            lmtt_pkg::ST_CL_RD2: integ_addr = {y1_reg - CW'(1), x2_reg};
            lmtt_pkg::ST_CL_RD3: integ_addr = {y1_reg - CW'(1), x1_reg - CW'(1)};
            default:             integ_addr = {y2_reg, x2_reg};
        endcase
    end
    assign integ_we  = (state_reg == lmtt_pkg::ST_LD_WR);
    assign samp_we   = (state_reg == lmtt_pkg::ST_LD_RD);
    assign samp_addr = samp_we ? {row_reg, col_reg} : {py_reg, px_reg};

    always_ff @(posedge aclk) begin
        if (integ_we) begin
            integ_mem[integ_addr] <= integ_wdata;
        end else begin
            integ_rdata_reg <= integ_mem[integ_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (samp_we) begin
            samp_mem[samp_addr] <= ld_sample_reg;
        end else begin
            samp_rdata_reg <= samp_mem[samp_addr];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        rowsum_next    = rowsum_reg;
        peak_next      = peak_reg;
        fc_next        = fc_reg;
        m_valid_next   = m_valid_reg;
        m_class_next   = m_class_reg;
        m_refused_next = m_refused_reg;
        ld_sample_next = ld_sample_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        x1_next        = x1_reg;
        x2_next        = x2_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        refuse_next    = refuse_reg;
        n_next         = n_reg;
        sn_next        = sn_reg;
        pn_next        = pn_reg;
        sum_next       = sum_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            lmtt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ld_sample_next = in_sample;
                    px_next        = in_x;
                    py_next        = in_y;
                    x1_next        = win_x1;
                    x2_next        = win_x2;
                    y1_next        = win_y1;
                    y2_next        = win_y2;
                    refuse_next    = in_refuse;
                    if (in_op == lmtt_pkg::OP_LOAD) begin
                        state_next = lmtt_pkg::ST_LD_RD;
                    end else if (in_refuse) begin
                        state_next = lmtt_pkg::ST_CL_RES;
                    end else begin
                        state_next = lmtt_pkg::ST_CL_RD0;
                    end
                end
            end
            lmtt_pkg::ST_LD_RD: begin
                state_next = lmtt_pkg::ST_LD_WR;
            end
            lmtt_pkg::ST_LD_WR: begin
                // first pixel starts a new frame: peak restarts from this sample
                if (ld_first) begin
                    peak_next = ld_sample_reg;
                    fc_next   = 1'b0;
                end else if (ld_sample_reg > peak_reg) begin
                    peak_next = ld_sample_reg;
                end
                rowsum_next = ld_rowsum;
                if (col_inc >= eff_w) begin
                    col_next = '0;
                    if (row_inc >= eff_h) begin
                        row_next = '0;
                        fc_next  = 1'b1;
                    end else begin
                        row_next = row_inc[CW-1:0];
                    end
                end else begin
                    col_next = col_inc[CW-1:0];
                end
                state_next = lmtt_pkg::ST_IDLE;
            end
            lmtt_pkg::ST_CL_RD0: begin
                n_next     = area[NW-1:0];
                state_next = lmtt_pkg::ST_CL_RD1;
            end
            lmtt_pkg::ST_CL_RD1: begin
                sum_next   = integ_rdata_reg;
                sn_next    = sn_prod;
                pn_next    = pn_prod;
                state_next = lmtt_pkg::ST_CL_RD2;
            end
            lmtt_pkg::ST_CL_RD2: begin
                if (x_lo) begin
                    sum_next = sum_reg - integ_rdata_reg;
                end
                state_next = lmtt_pkg::ST_CL_RD3;
            end
            lmtt_pkg::ST_CL_RD3: begin
                if (y_lo) begin
                    sum_next = sum_reg - integ_rdata_reg;
                end
                state_next = lmtt_pkg::ST_CL_SUM;
            end
            lmtt_pkg::ST_CL_SUM: begin
                if (x_lo && y_lo) begin
                    sum_next = sum_reg + integ_rdata_reg;
                end
                state_next = lmtt_pkg::ST_CL_RES;
            end
            lmtt_pkg::ST_CL_RES: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_class_next   = refuse_reg ? lmtt_pkg::CLS_CERTAIN_BG : cls;
                    m_refused_next = refuse_reg;
                    state_next     = lmtt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lmtt_pkg::ST_IDLE;
            end
        endcase

        // register write restarts loading; the user must write only while idle, the block does not enforce it
        if (cfg_wr) begin
            if (paddr[2] == lmtt_pkg::REG_HEIGHT) begin
                height_next = pwdata[DW-1:0];
            end else begin
                width_next = pwdata[DW-1:0];
            end
            col_next    = '0;
            row_next    = '0;
            rowsum_next = '0;
            fc_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lmtt_pkg::ST_IDLE;
            width_reg   <= lmtt_pkg::MAX_WIDTH_V;
            height_reg  <= lmtt_pkg::MAX_HEIGHT_V;
            col_reg     <= '0;
            row_reg     <= '0;
            rowsum_reg  <= '0;
            peak_reg    <= '0;
            fc_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            rowsum_reg  <= rowsum_next;
            peak_reg    <= peak_next;
            fc_reg      <= fc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_class_reg   <= m_class_next;
        m_refused_reg <= m_refused_next;
        ld_sample_reg <= ld_sample_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        x1_reg        <= x1_next;
        x2_reg        <= x2_next;
        y1_reg        <= y1_next;
        y2_reg        <= y2_next;
        refuse_reg    <= refuse_next;
        n_reg         <= n_next;
        sn_reg        <= sn_next;
        pn_reg        <= pn_next;
        sum_reg       <= sum_next;
    end

endmodule

FILE: design/lmtt_checker.sv
// Port-level assertions for the local mean triple threshold block, with bind.
`timescale 1ns / 1ps

module lmtt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lmtt_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    // a refused item always reports certain background
    a_refused_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[1:0] == lmtt_pkg::CLS_CERTAIN_BG))
        else $error("refused item with nonzero class");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after an accepted item");

    // a load never makes a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == lmtt_pkg::OP_LOAD) && !m_tvalid) |=> !m_tvalid)
        else $error("result appeared after a load");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind local_mean_triple_threshold lmtt_checker u_lmtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/tb_local_mean_triple_threshold.sv
// Self-checking testbench for the local mean triple threshold classifier.
`timescale 1ns / 1ps

module tb_local_mean_triple_threshold;

    localparam int PIXELS       = lmtt_pkg::MAX_WIDTH * lmtt_pkg::MAX_HEIGHT;
    localparam int SETTLE       = 12;      // a load can still be in flight after the last result
    localparam int DRAIN_MAX    = 20000;
    localparam int RANDOM_ITEMS = 120;
    localparam int STEADY_ITEMS = 50;      // opening stretch of the random part with no idling

    typedef struct packed {
        logic [1:0] cls;
        logic       refused;
    } verdict_t;

    typedef enum int {TEX_NOISE, TEX_SPARSE, TEX_FLAT, TEX_EXTREME} texture_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    // [7:0] sample, [16:8] pixel_x, [25:17] pixel_y
    logic [lmtt_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                             s_tuser;      // [0] opcode
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [lmtt_pkg::M_TDATA_W-1:0]   m_tdata;      // [1:0] class_code
    logic                             m_tuser;      // [0] refused
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [lmtt_pkg::APB_AW-1:0]      paddr;
    logic [lmtt_pkg::APB_DW-1:0]      pwdata;
    logic [lmtt_pkg::APB_DW-1:0]      prdata;
    logic                             pready;

    // predictor state
    logic [lmtt_pkg::SAMPLE_W-1:0]    pixel_mem [PIXELS];
    logic [lmtt_pkg::INTEG_W-1:0]     integ_mem [PIXELS];
    int unsigned                      row_acc;
    int unsigned                      frame_peak;
    int unsigned                      load_col;
    int unsigned                      load_row;
    bit                               frame_ready;
    logic [lmtt_pkg::DIM_W-1:0]       cfg_width;
    logic [lmtt_pkg::DIM_W-1:0]       cfg_height;

    verdict_t                         pending_verdicts[$];
    int unsigned                      errors;
    int unsigned                      items_sent;
    bit                               steady;

    local_mean_triple_threshold u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 8);
    end

    function automatic int unsigned clamp_dim(logic [lmtt_pkg::DIM_W-1:0] v,
                                              int unsigned top);
        if (v == '0) return 1;
        return (v > top) ? top : 32'(v);
    endfunction

    function automatic int unsigned pix_addr(int unsigned x, int unsigned y);
        return y * lmtt_pkg::MAX_WIDTH + x;
    endfunction

    function automatic void restart_frame();
        row_acc     = 0;
        load_col    = 0;
        load_row    = 0;
        frame_ready = 1'b0;
    endfunction

    // raster load: sample store, integral image, frame peak
    function automatic void store_sample(int unsigned s);
        int unsigned w, h, above;
        w = clamp_dim(cfg_width, lmtt_pkg::MAX_WIDTH);
        h = clamp_dim(cfg_height, lmtt_pkg::MAX_HEIGHT);
        if (load_col == 0 && load_row == 0) begin
            frame_ready = 1'b0;
            frame_peak  = 0;
        end
        if (load_col == 0) row_acc = 0;
        if (s > frame_peak) frame_peak = s;
        row_acc += s;
        above = (load_row > 0) ? 32'(integ_mem[pix_addr(load_col, load_row - 1)]) : 0;
        pixel_mem[pix_addr(load_col, load_row)] = lmtt_pkg::SAMPLE_W'(s);
        integ_mem[pix_addr(load_col, load_row)] = lmtt_pkg::INTEG_W'(row_acc + above);
        load_col++;
        if (load_col >= w) begin
            load_col = 0;
            load_row++;
            if (load_row >= h) begin
                load_row    = 0;
                frame_ready = 1'b1;
            end
        end
    endfunction

    // box mean over the clipped window, compared by cross-multiplication
    function automatic verdict_t judge_pixel(int unsigned x, int unsigned y);
        int unsigned     w, h, half, x1, y1, x2, y2, box;
        longint unsigned cnt, box_l, s_n, p_n;
        verdict_t        v;
        w = clamp_dim(cfg_width, lmtt_pkg::MAX_WIDTH);
        h = clamp_dim(cfg_height, lmtt_pkg::MAX_HEIGHT);
        v.cls     = lmtt_pkg::CLS_CERTAIN_BG;
        v.refused = 1'b1;
        if (!frame_ready || x >= w || y >= h) return v;
        half = ((w / 2 < 2) ? 2 : w / 2) / 2;
        x1 = (x > half) ? x - half : 0;
        y1 = (y > half) ? y - half : 0;
        x2 = (x + half > w - 1) ? w - 1 : x + half;
        y2 = (y + half > h - 1) ? h - 1 : y + half;
        box = 32'(integ_mem[pix_addr(x2, y2)]);
        if (x1 > 0) box -= 32'(integ_mem[pix_addr(x1 - 1, y2)]);
        if (y1 > 0) box -= 32'(integ_mem[pix_addr(x2, y1 - 1)]);
        if (x1 > 0 && y1 > 0) box += 32'(integ_mem[pix_addr(x1 - 1, y1 - 1)]);
        cnt   = longint'(x2 - x1 + 1) * longint'(y2 - y1 + 1);
        box_l = box;
        s_n   = longint'(pixel_mem[pix_addr(x, y)]) * cnt;
        p_n   = longint'(frame_peak) * cnt;
        v.refused = 1'b0;
        if (s_n <= box_l) v.cls = lmtt_pkg::CLS_CERTAIN_BG;
        else if (2 * s_n > box_l + p_n) v.cls = lmtt_pkg::CLS_CERTAIN_FG;
        else if (4 * s_n <= 3 * box_l + p_n) v.cls = lmtt_pkg::CLS_PROBABLE_BG;
        else v.cls = lmtt_pkg::CLS_PROBABLE_FG;
        return v;
    endfunction

    function automatic logic [lmtt_pkg::SAMPLE_W-1:0] pick_sample(texture_t tex);
        case (tex)
            TEX_SPARSE:  return ($urandom_range(0, 99) < 10)
                                ? lmtt_pkg::SAMPLE_W'($urandom_range(200, 255))
                                : lmtt_pkg::SAMPLE_W'($urandom_range(0, 20));
            TEX_FLAT:    return lmtt_pkg::SAMPLE_W'($urandom_range(100, 108));
            TEX_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default:     return lmtt_pkg::SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // one item on the input channel; prediction happens at the accepting edge
    task automatic push_item(logic op, logic [lmtt_pkg::SAMPLE_W-1:0] smp,
                             logic [lmtt_pkg::COORD_W-1:0] px,
                             logic [lmtt_pkg::COORD_W-1:0] py);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 8) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= lmtt_pkg::S_TDATA_W'({py, px, smp});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == lmtt_pkg::OP_LOAD) store_sample(32'(smp));
        else pending_verdicts.push_back(judge_pixel(32'(px), 32'(py)));
        items_sent++;
    endtask

    task automatic drain_results();
        int unsigned waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_verdicts.size());
            errors++;
            pending_verdicts.delete();
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    // setup + access; upper data bits carry noise the register must drop
    task automatic write_reg(logic reg_sel, logic [lmtt_pkg::DIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {$urandom_range(0, 3) == 0 ? 22'($urandom()) : 22'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_sel == lmtt_pkg::REG_WIDTH) cfg_width = value;
        else cfg_height = value;
        restart_frame();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(logic [lmtt_pkg::DIM_W-1:0] w_reg,
                             logic [lmtt_pkg::DIM_W-1:0] h_reg,
                             bit do_w, bit do_h);
        drain_results();
        if (do_w) write_reg(lmtt_pkg::REG_WIDTH, w_reg);
        if (do_h) write_reg(lmtt_pkg::REG_HEIGHT, h_reg);
    endtask

    task automatic fill_frame(texture_t tex, int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            push_item(lmtt_pkg::OP_LOAD, pick_sample(tex),
                      lmtt_pkg::COORD_W'($urandom_range(0, 511)),
                      lmtt_pkg::COORD_W'($urandom_range(0, 511)));
        end
    endtask

    // classify requests, a share of them anywhere in the coordinate range
    task automatic classify_some(int unsigned count, int unsigned stray_pct);
        int unsigned w, h;
        w = clamp_dim(cfg_width, lmtt_pkg::MAX_WIDTH);
        h = clamp_dim(cfg_height, lmtt_pkg::MAX_HEIGHT);
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < stray_pct) begin
                push_item(lmtt_pkg::OP_CLASSIFY,
                          lmtt_pkg::SAMPLE_W'($urandom_range(0, 255)),
                          lmtt_pkg::COORD_W'($urandom_range(0, 511)),
                          lmtt_pkg::COORD_W'($urandom_range(0, 511)));
            end else begin
                push_item(lmtt_pkg::OP_CLASSIFY,
                          lmtt_pkg::SAMPLE_W'($urandom_range(0, 255)),
                          lmtt_pkg::COORD_W'($urandom_range(0, w - 1)),
                          lmtt_pkg::COORD_W'($urandom_range(0, h - 1)));
            end
        end
    endtask

    // default 512x512 frame is never complete this early
    task automatic test_after_reset();
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd255, 9'd511, 9'd511);
        fill_frame(TEX_NOISE, 3);
    endtask

    task automatic test_directed();
        set_frame(10'd3, 10'd2, 1'b1, 1'b1);
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd1, 9'd1);     // incomplete frame
        push_item(lmtt_pkg::OP_LOAD, 8'd0, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_LOAD, 8'd255, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_LOAD, 8'd17, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_LOAD, 8'd255, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_LOAD, 8'd0, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_LOAD, 8'd128, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd0, 9'd0);
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd1, 9'd0);
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd2, 9'd1);
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd3, 9'd0);     // just right of the image
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd0, 9'd2);     // just below the image
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd255, 9'd511, 9'd511);
        push_item(lmtt_pkg::OP_LOAD, 8'd90, 9'd0, 9'd0);        // new frame drops completion
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd0, 9'd0);
        fill_frame(TEX_FLAT, 5);
        push_item(lmtt_pkg::OP_CLASSIFY, 8'd0, 9'd1, 9'd0);
    endtask

    // zero and over-range register values, widest row and tallest column
    task automatic test_dim_extremes();
        logic [lmtt_pkg::DIM_W-1:0] dims [4][2];
        dims = '{'{10'd0, 10'd0}, '{10'd1023, 10'd1}, '{10'd1, 10'd1023},
                 '{10'd2, 10'd1}};
        for (int i = 0; i < 4; i++) begin
            set_frame(dims[i][0], dims[i][1], 1'b1, 1'b1);
            fill_frame(texture_t'($urandom_range(0, 3)),
                       clamp_dim(cfg_width, lmtt_pkg::MAX_WIDTH) *
                       clamp_dim(cfg_height, lmtt_pkg::MAX_HEIGHT));
            classify_some(16, 10);
        end
    endtask

    // small frames with random content; some broken off, some reloaded over
    task automatic test_random_frames();
        int unsigned start, total, part, mode, which;
        logic [lmtt_pkg::DIM_W-1:0] w_reg, h_reg;
        texture_t tex;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            steady = (items_sent - start < STEADY_ITEMS);
            if ($urandom_range(0, 99) < 85) begin
                w_reg = lmtt_pkg::DIM_W'($urandom_range(1, 12));
                h_reg = lmtt_pkg::DIM_W'($urandom_range(1, 12));
            end else begin
                w_reg = lmtt_pkg::DIM_W'($urandom_range(13, 48));
                h_reg = lmtt_pkg::DIM_W'($urandom_range(1, 6));
            end
            if ($urandom_range(0, 99) < 5) w_reg = '0;
            if ($urandom_range(0, 99) < 5) h_reg = '0;
            which = $urandom_range(0, 3);
            set_frame(w_reg, h_reg, which != 2, which != 1);
            total = clamp_dim(cfg_width, lmtt_pkg::MAX_WIDTH) *
                    clamp_dim(cfg_height, lmtt_pkg::MAX_HEIGHT);
            tex   = texture_t'($urandom_range(0, 3));
            mode  = $urandom_range(0, 99);
            if (mode < 12) begin
                // cut short; the next register write restarts loading
                fill_frame(tex, $urandom_range(0, total - 1));
                classify_some(3, 30);
            end else begin
                fill_frame(tex, total);
                classify_some($urandom_range(4, 16), 15);
                if (mode < 30) begin
                    part = $urandom_range(1, total);
                    fill_frame(tex, part);
                    classify_some(2, 0);
                    fill_frame(tex, total - part);
                    classify_some(6, 15);
                end
            end
        end
        steady = 1'b0;
    endtask

    // checks every result against the oldest prediction
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected: tdata %0h tuser %0b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata !== lmtt_pkg::M_TDATA_W'(want.cls)) begin
                    $display("%0t: class mismatch: expected %0h actual %0h",
                             $time, lmtt_pkg::M_TDATA_W'(want.cls), m_tdata);
                    errors++;
                end
                if (m_tuser !== want.refused) begin
                    $display("%0t: refused mismatch: expected %0b actual %0b",
                             $time, want.refused, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        errors     = 0;
        items_sent = 0;
        steady     = 1'b0;
        cfg_width  = lmtt_pkg::MAX_WIDTH_V;
        cfg_height = lmtt_pkg::MAX_HEIGHT_V;
        frame_peak = 0;
        restart_frame();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_directed();
        test_dim_extremes();
        test_random_frames();
        drain_results();

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: local_mean_triple_threshold.f
design/lmtt_pkg.sv
design/local_mean_triple_threshold.sv
design/lmtt_checker.sv
tb/tb_local_mean_triple_threshold.sv
